// ----- hdl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRI_W    = 8;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] item_value;
        logic [PRI_W-1:0]          item_priority;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      found;
        logic                      is_empty;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] head_value;
        logic [PRI_W-1:0]          head_priority;
    } result_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRI_W-1:0]          prio;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_UP_RD,
        ST_UP_WR,
        ST_INS_WR,
        ST_DN_RD,
        ST_DN_WR,
        ST_HEAD_RD,
        ST_HEAD_CHK
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/sorted_priority_store.sv -----
// Sorted (value, priority) store in one single-port-style RAM, head at slot 0.
// Push scans for its slot, moves later entries up one slot and writes the new entry;
// pop and a delete hit move later entries down; lookup scans; every item ends with a
// head read. A result that is not taken holds the block until the output register
// frees. One item at a time; each scanned or moved entry costs one RAM read state and one write or check state.
// Reset clears the entry count and the handshake state; RAM contents are not cleared.
`default_nettype none

module sorted_priority_store #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spq_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spq_pkg::result_t       out_data
);

    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PRI_W-1:0] PRI_MASK =
        (PRIORITY_BITS >= PRI_W) ? {PRI_W{1'b1}} : PRI_W'((1 << PRIORITY_BITS) - 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [PRI_W-1:0]  pri_reg, pri_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    slot_t             ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    slot_t             ram_rd_data;

    logic [CW-1:0]     idx_p1;
    logic [CW-1:0]     idx_m1;
    logic [31:0]       count_ext;

    spq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign idx_p1    = idx_reg + CW'(1);
    assign idx_m1    = idx_reg - CW'(1);
    assign count_ext = 32'(count_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        pri_reg      <= pri_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pri_next       = pri_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_data.mode;
                    val_next    = in_data.item_value;
                    pri_next    = in_data.item_priority & PRI_MASK;
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    pos_next    = '0;
                    unique case (in_data.mode)
                        MODE_PUSH:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_HEAD_RD;
                            end
                            else
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_HEAD_RD;
                            end
                            else
                            begin
                                state_next = ST_DN_RD;
                            end
                        end
                        MODE_DELETE, MODE_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_HEAD_RD;
                            end
                            else
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_HEAD_RD;
                        end
                        default:
                        begin
                            state_next = ST_HEAD_RD;
                        end
                    endcase
                end
            end

            ST_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // walked off the tail: push appends, delete misses, lookup misses
                    priority if (op_reg == MODE_PUSH)
                    begin
                        pos_next   = idx_reg;
                        state_next = ST_UP_RD;
                    end
                    else if (op_reg == MODE_DELETE)
                    begin
                        status_next = STATUS_NOT_FOUND;
                        state_next  = ST_HEAD_RD;
                    end
                    else
                    begin
                        state_next = ST_HEAD_RD;
                    end
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg[AW-1:0];
                    state_next  = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                priority if (op_reg == MODE_PUSH && ram_rd_data.prio >= pri_reg)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = ST_UP_RD;
                end
                else if (op_reg == MODE_DELETE && ram_rd_data.prio == pri_reg)
                begin
                    state_next = ST_DN_RD;
                end
                else if (op_reg == MODE_LOOKUP && ram_rd_data.prio == pri_reg
                         && ram_rd_data.value == val_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = ST_SCAN_RD;
                end
            end

            // open a hole at pos by moving entries up one slot, tail first
            ST_UP_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_m1[AW-1:0];
                    state_next  = ST_UP_WR;
                end
            end

            ST_UP_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
                idx_next    = idx_m1;
                state_next  = ST_UP_RD;
            end

            ST_INS_WR:
            begin
                ram_wr_en         = 1'b1;
                ram_wr_addr       = pos_reg[AW-1:0];
                ram_wr_data.value = val_reg;
                ram_wr_data.prio  = pri_reg;
                count_next        = count_reg + CW'(1);
                state_next        = ST_HEAD_RD;
            end

            // close the gap at idx by moving later entries down one slot
            ST_DN_RD:
            begin
                if (idx_p1 >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_p1[AW-1:0];
                    state_next  = ST_DN_WR;
                end
            end

            ST_DN_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
                idx_next    = idx_p1;
                state_next  = ST_DN_RD;
            end

            ST_HEAD_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                state_next  = ST_HEAD_CHK;
            end

            // RAM read data holds here until the output register frees up
            ST_HEAD_CHK:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = status_reg;
                    out_data_next.found       = found_reg;
                    out_data_next.is_empty    = (count_reg == '0);
                    out_data_next.entry_count = count_ext[COUNT_W-1:0];
                    if (count_reg == '0)
                    begin
                        out_data_next.head_value    = '0;
                        out_data_next.head_priority = '0;
                    end
                    else
                    begin
                        out_data_next.head_value    = ram_rd_data.value;
                        out_data_next.head_priority = ram_rd_data.prio;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/spq_ram.sv -----
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int RANDOM_OPS   = 1024;
    localparam int DRAIN_CYCLES = 48;   // sized to cover the longest op

    // modes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        in_item_t stim;
        bit       typed;
        result_t  want;
    } op_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    in_item_t in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    result_t  out_data;

    slot_t   shadow_slots[$];
    result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int ops_by_mode[8];
    int full_refusals = 0;
    int empty_hits = 0;
    int absent_deletes = 0;
    int lookup_hits = 0;

    sorted_priority_store #(
        .CAPACITY(STORE_DEPTH),
        .PRIORITY_BITS(PRI_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic in_item_t make_op(logic [MODE_W-1:0] m, logic signed [VALUE_W-1:0] v,
                                         logic [PRI_W-1:0] p);
        in_item_t it;
        it.mode = m;
        it.item_value = v;
        it.item_priority = p;
        return it;
    endfunction

    // result of any op that leaves the store empty
    function automatic result_t empty_result(logic [STATUS_W-1:0] st);
        result_t r;
        r = '0;
        r.status = st;
        r.is_empty = 1'b1;
        return r;
    endfunction

    // shadow of the sorted store: apply one op, return what the block should report
    function automatic result_t apply_store_op(in_item_t op);
        result_t r;
        slot_t   s;
        int      pos;
        r = '0;
        ops_by_mode[op.mode]++;
        case (op.mode)
            MODE_PUSH:
            begin
                if (shadow_slots.size() >= STORE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                    full_refusals++;
                end
                else
                begin
                    pos = 0;
                    // newest of equal priority lands nearest the head
                    while (pos < shadow_slots.size() && shadow_slots[pos].prio < op.item_priority)
                        pos++;
                    s.value = op.item_value;
                    s.prio = op.item_priority;
                    shadow_slots.insert(pos, s);
                end
            end
            MODE_POP:
            begin
                if (shadow_slots.size() == 0)
                    r.status = STATUS_EMPTY;
                else
                    void'(shadow_slots.pop_front());
            end
            MODE_DELETE:
            begin
                if (shadow_slots.size() == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < shadow_slots.size() && shadow_slots[pos].prio != op.item_priority)
                        pos++;
                    if (pos < shadow_slots.size())
                        shadow_slots.delete(pos);
                    else
                    begin
                        r.status = STATUS_NOT_FOUND;
                        absent_deletes++;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                if (shadow_slots.size() == 0)
                    r.status = STATUS_EMPTY;
                else
                    foreach (shadow_slots[i])
                        if (shadow_slots[i].prio == op.item_priority &&
                            shadow_slots[i].value == op.item_value)
                            r.found = 1'b1;
                if (r.found)
                    lookup_hits++;
            end
            MODE_CLEAR:
                shadow_slots.delete();
            default:
                ;
        endcase
        if (r.status == STATUS_EMPTY)
            empty_hits++;
        r.is_empty = (shadow_slots.size() == 0);
        r.entry_count = COUNT_W'(shadow_slots.size());
        if (shadow_slots.size() != 0)
        begin
            r.head_value = shadow_slots[0].value;
            r.head_priority = shadow_slots[0].prio;
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_op(input in_item_t op, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_store_op(op);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_ready = rst_n && ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic compare_result(input result_t exp, input result_t got);
        if (got.status !== exp.status)
        begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            mismatch_count++;
        end
        if (got.found !== exp.found)
        begin
            $error("found: expected %0d, got %0d", exp.found, got.found);
            mismatch_count++;
        end
        if (got.is_empty !== exp.is_empty)
        begin
            $error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
            mismatch_count++;
        end
        if (got.entry_count !== exp.entry_count)
        begin
            $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
            mismatch_count++;
        end
        if (got.head_value !== exp.head_value)
        begin
            $error("head_value: expected %0d, got %0d", exp.head_value, got.head_value);
            mismatch_count++;
        end
        if (got.head_priority !== exp.head_priority)
        begin
            $error("head_priority: expected %0d, got %0d", exp.head_priority,
                   got.head_priority);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending");
                mismatch_count++;
            end
            else
                compare_result(pending_results.pop_front(), out_data);
        end
    end

    function automatic logic [PRI_W-1:0] pick_priority();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return PRI_W'($urandom_range(0, 7));
        else if (roll < 85)
            return PRI_W'($urandom_range(0, 255));
        return roll[0] ? 8'hFF : 8'h00;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // ops biased toward filling or emptying so the count sweeps the whole range
    function automatic in_item_t next_random_op(bit growing);
        int    roll;
        slot_t pick;
        in_item_t op;
        roll = $urandom_range(0, 99);
        op = make_op(MODE_PUSH, pick_value(), pick_priority());
        if (shadow_slots.size() != 0)
            pick = shadow_slots[$urandom_range(0, shadow_slots.size() - 1)];
        if (roll < 2)
            op.mode = MODE_CLEAR;
        else if (roll < 5)
            op.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else if (growing ? roll < 65 : roll >= 90)
            op.mode = MODE_PUSH;
        else if (growing ? roll >= 90 : roll < 40)
            op.mode = MODE_POP;
        else if (growing ? roll >= 80 : roll < 70)
        begin
            op.mode = MODE_DELETE;
            if (shadow_slots.size() != 0 && $urandom_range(0, 4) != 0)
                op.item_priority = pick.prio;
        end
        else
        begin
            op.mode = MODE_LOOKUP;
            if (shadow_slots.size() != 0)
            begin
                roll = $urandom_range(0, 3);
                if (roll < 2)
                begin
                    op.item_value = pick.value;
                    op.item_priority = pick.prio;
                end
                else if (roll == 2)
                begin
                    op.item_value = pick.value ^ (32'sd1 << $urandom_range(0, 31));
                    op.item_priority = pick.prio;
                end
            end
        end
        return op;
    endfunction

    initial
    begin
        op_row_t drill[$];
        logic [PRI_W-1:0] fill_prio[16];
        logic signed [VALUE_W-1:0] fill_val[16];
        result_t full_want;
        in_item_t op;
        bit growing;
        int counted;
        int target;

        fill_prio = '{8'd255, 8'd128, 8'd0, 8'd128, 8'd255, 8'd7, 8'd7, 8'd42,
                      8'd200, 8'd1, 8'd254, 8'd64, 8'd64, 8'd3, 8'd90, 8'd150};
        fill_val = '{VAL_MAX, 32'sd17, VAL_MIN, -32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sd0, 32'sd4242, 32'sd200, -32'sd77, 32'sh0F0F_0F0F, 32'sd64,
                     32'sd65, 32'sh1234_5678, -32'sd90, 32'sd150};

        // empty-store cases and ignored modes right after reset
        drill.push_back('{make_op(MODE_POP, 32'sd1, 8'd0), 1'b1, empty_result(STATUS_EMPTY)});
        drill.push_back('{make_op(MODE_DELETE, 32'sd0, 8'd255), 1'b1,
                          empty_result(STATUS_EMPTY)});
        drill.push_back('{make_op(MODE_LOOKUP, VAL_MAX, 8'd255), 1'b1,
                          empty_result(STATUS_EMPTY)});
        drill.push_back('{make_op(MODE_SPARE_LO, VAL_MIN, 8'd0), 1'b1,
                          empty_result(STATUS_OK)});
        drill.push_back('{make_op(MODE_SPARE_HI, -32'sd1, 8'hFF), 1'b1,
                          empty_result(STATUS_OK)});
        // fill to capacity, with ties and both priority extremes
        foreach (fill_prio[i])
            drill.push_back('{make_op(MODE_PUSH, fill_val[i], fill_prio[i]), 1'b0, '0});
        // refused push: would have become the new head
        full_want = '0;
        full_want.status = STATUS_FULL;
        full_want.entry_count = COUNT_W'(STORE_DEPTH);
        full_want.head_value = VAL_MIN;
        full_want.head_priority = 8'd0;
        drill.push_back('{make_op(MODE_PUSH, 32'sd123, 8'd0), 1'b1, full_want});
        drill.push_back('{make_op(MODE_LOOKUP, 32'sd4242, 8'd42), 1'b0, '0});
        drill.push_back('{make_op(MODE_DELETE, 32'sd0, 8'd100), 1'b0, '0});
        drill.push_back('{make_op(MODE_POP, 32'sd0, 8'd0), 1'b0, '0});
        drill.push_back('{make_op(MODE_CLEAR, 32'sd0, 8'd0), 1'b1, empty_result(STATUS_OK)});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 29 : 0;
            if (phase == 0)
                foreach (drill[i])
                    send_op(drill[i].stim, drill[i].typed, drill[i].want);
            growing = 1'b1;
            counted = 0;
            target = (phase == 2) ? RANDOM_OPS - 2 * (RANDOM_OPS / 3) : RANDOM_OPS / 3;
            while (counted < target)
            begin
                if (shadow_slots.size() == STORE_DEPTH && $urandom_range(0, 3) == 0)
                    growing = 1'b0;
                else if (shadow_slots.size() == 0 && $urandom_range(0, 3) == 0)
                    growing = 1'b1;
                op = next_random_op(growing);
                send_op(op, 1'b0, '0);
                if (op.mode <= MODE_CLEAR)
                    counted++;
            end
        end
        in_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ops: push %0d, pop %0d, delete %0d, lookup %0d, clear %0d, ignored %0d",
                 ops_by_mode[MODE_PUSH], ops_by_mode[MODE_POP], ops_by_mode[MODE_DELETE],
                 ops_by_mode[MODE_LOOKUP], ops_by_mode[MODE_CLEAR],
                 ops_by_mode[5] + ops_by_mode[6] + ops_by_mode[7]);
        $display("refused on full %0d, hit empty %0d, absent deletes %0d, lookup hits %0d",
                 full_refusals, empty_hits, absent_deletes, lookup_hits);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting for transfers");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/sorted_priority_store.sv
tb/testbench.sv
